// ===== rtl/u2u_pkg.sv =====
`default_nettype none

package u2u_pkg;

  // Field widths of the byte and unit channels.
  localparam int BYTE_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int TOT_W   = 31;
  localparam int CP_W    = 21;
  localparam int MAX_W   = 31;

  // Default width of the saturating unit counter.
  localparam int COUNT_BITS_DEF = 31;

  // Result queue geometry.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Code point and surrogate constants.
  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
  localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

  // One result item as held in the output queue.
  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              unit_valid;
    logic              last_of_item;
    logic              end_of_stream;
    logic [TOT_W-1:0]  total_units;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/u2u_in_if.sv =====
`default_nettype none

interface u2u_in_if;
  import u2u_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/u2u_out_if.sv =====
`default_nettype none

interface u2u_out_if;
  import u2u_pkg::*;

  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              unit_valid;
  logic              last_of_item;
  logic              end_of_stream;
  logic [TOT_W-1:0]  total_units;

  modport source (output valid, output code_unit, output unit_valid, output last_of_item,
                  output end_of_stream, output total_units, input ready);
  modport sink   (input valid, input code_unit, input unit_valid, input last_of_item,
                  input end_of_stream, input total_units, output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8_to_utf16_decoder.sv =====
// A result item is written into the registered result queue when its byte is accepted.
// Bytes are accepted one per cycle while two result slots are free; a surrogate pair fills two queue entries.
// Input ready comes from the registered fill level of a four-entry result queue,
// which accepts a byte whenever two result slots are free.
// Reset (rst_n, synchronous, active low) clears the decode state, the unit counter,
// the capacity register and the queue.
`default_nettype none

module utf8_to_utf16_decoder #(
  parameter int COUNT_BITS = u2u_pkg::COUNT_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  u2u_in_if.sink                          in_ch,
  u2u_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [u2u_pkg::MAX_W-1:0]  cfg_wdata
);
  import u2u_pkg::*;

  localparam int EXT_W = COUNT_BITS + TOT_W;
  localparam int CMP_W = ((COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W) + 2;

  // Counter value as reported on total_units.
  function automatic logic [TOT_W-1:0] to_tot(input logic [COUNT_BITS-1:0] x);
    logic [EXT_W-1:0] e;
    e = {{TOT_W{1'b0}}, x};
    return e[TOT_W-1:0];
  endfunction

  logic [MAX_W-1:0]      max_r;
  logic [1:0]            pend_r, pend_nxt;
  logic [CP_W-1:0]       pcp_r, pcp_nxt;
  logic [COUNT_BITS-1:0] units_r, units_nxt;
  logic                  stopped_r, stopped_nxt;

  res_t                  q_r [Q_DEPTH];
  logic [Q_AW-1:0]       head_r;
  logic [Q_CW-1:0]       count_r, count_nxt;

  logic                  accept, pop;
  logic [BYTE_W-1:0]     b;

  // Sequence decode results.
  logic [1:0]            pend_d;
  logic [CP_W-1:0]       pcp_d;
  logic                  have_cp;
  logic [CP_W-1:0]       cp;
  logic                  as_lead;

  // Unit generation.
  logic                  need2, over;
  logic [CMP_W-1:0]      units_ext, max_ext, sum_ext;
  logic [COUNT_BITS-1:0] u1, u2;
  logic [CP_W-1:0]       v;
  logic [UNIT_W-1:0]     hi_unit, lo_unit;
  res_t                  e0, e1;
  logic [1:0]            push;
  logic [Q_AW-1:0]       tail0, tail1;

  assign b      = in_ch.byte_in;
  assign accept = in_ch.valid && in_ch.ready;
  assign pop    = out_ch.valid && out_ch.ready;

  // A byte may make two results, so two free slots are required.
  assign in_ch.ready = (count_r <= Q_CW'(Q_DEPTH - 2));

  // Continuation and lead byte decode.
  always_comb begin
    pend_d  = pend_r;
    pcp_d   = pcp_r;
    have_cp = 1'b0;
    cp      = '0;
    as_lead = 1'b1;
    if (!stopped_r) begin
      if (pend_r != 2'd0) begin
        if (b[7:6] == 2'b10) begin
          as_lead = 1'b0;
          pcp_d   = {pcp_r[CP_W-7:0], b[5:0]};
          pend_d  = pend_r - 2'd1;
          if (pend_d == 2'd0) begin
            have_cp = 1'b1;
            cp      = pcp_d;
            pcp_d   = '0;
          end
        end else begin
          // Broken sequence: drop it and decode this byte as a fresh lead.
          pend_d = 2'd0;
          pcp_d  = '0;
        end
      end
      if (as_lead) begin
        if (!b[7]) begin
          have_cp = 1'b1;
          cp      = {{(CP_W-8){1'b0}}, b};
        end else if (!b[6]) begin
          // Stray continuation byte is dropped.
        end else if (!b[5]) begin
          pcp_d  = {{(CP_W-5){1'b0}}, b[4:0]};
          pend_d = 2'd1;
        end else if (!b[4]) begin
          pcp_d  = {{(CP_W-4){1'b0}}, b[3:0]};
          pend_d = 2'd2;
        end else if (!b[3]) begin
          pcp_d  = {{(CP_W-3){1'b0}}, b[2:0]};
          pend_d = 2'd3;
        end
      end
    end
  end

  // Capacity check, saturating count and surrogate split.
  always_comb begin
    need2     = (cp[CP_W-1:16] != '0);
    units_ext = CMP_W'(units_r);
    max_ext   = CMP_W'(max_r);
    sum_ext   = units_ext + (need2 ? CMP_W'(2) : CMP_W'(1));
    over      = (max_r != '0) && (sum_ext > max_ext);
    u1        = (units_r != '1) ? units_r + 1'b1 : units_r;
    u2        = (u1 != '1) ? u1 + 1'b1 : u1;
    v         = cp - SUPP_BASE;
    hi_unit   = HI_SURR + {5'b0, v[20:10]};
    lo_unit   = LO_SURR + {6'b0, v[9:0]};
  end

  // Result items and next stream state.
  always_comb begin
    e0          = '0;
    e1          = '0;
    push        = 2'd0;
    pend_nxt    = pend_d;
    pcp_nxt     = pcp_d;
    units_nxt   = units_r;
    stopped_nxt = stopped_r;
    if (have_cp && over) begin
      stopped_nxt = 1'b1;
      pend_nxt    = 2'd0;
      pcp_nxt     = '0;
    end else if (have_cp && !need2) begin
      e0.code_unit     = cp[UNIT_W-1:0];
      e0.unit_valid    = 1'b1;
      e0.last_of_item  = 1'b1;
      e0.end_of_stream = in_ch.last_byte;
      e0.total_units   = to_tot(u1);
      push             = 2'd1;
      units_nxt        = u1;
    end else if (have_cp) begin
      e0.code_unit     = hi_unit;
      e0.unit_valid    = 1'b1;
      e0.total_units   = to_tot(u1);
      e1.code_unit     = lo_unit;
      e1.unit_valid    = 1'b1;
      e1.last_of_item  = 1'b1;
      e1.end_of_stream = in_ch.last_byte;
      e1.total_units   = to_tot(u2);
      push             = 2'd2;
      units_nxt        = u2;
    end
    // Final byte with no unit gives a bare end marker.
    if (push == 2'd0 && in_ch.last_byte) begin
      e0.last_of_item  = 1'b1;
      e0.end_of_stream = 1'b1;
      e0.total_units   = to_tot(units_r);
      push             = 2'd1;
    end
    if (in_ch.last_byte) begin
      pend_nxt    = 2'd0;
      pcp_nxt     = '0;
      units_nxt   = '0;
      stopped_nxt = 1'b0;
    end
  end

  // Control registers and stream state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r     <= '0;
      pend_r    <= 2'd0;
      pcp_r     <= '0;
      units_r   <= '0;
      stopped_r <= 1'b0;
      head_r    <= '0;
      count_r   <= '0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (accept) begin
        pend_r    <= pend_nxt;
        pcp_r     <= pcp_nxt;
        units_r   <= units_nxt;
        stopped_r <= stopped_nxt;
      end
      if (pop) begin
        head_r <= head_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Queue fill level.
  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = count_nxt + Q_CW'(push);
    end
    if (pop) begin
      count_nxt = count_nxt - 1'b1;
    end
  end

  assign tail0 = head_r + count_r[Q_AW-1:0];
  assign tail1 = tail0 + 1'b1;

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (accept && push != 2'd0) begin
      q_r[tail0] <= e0;
    end
    if (accept && push == 2'd2) begin
      q_r[tail1] <= e1;
    end
  end

  assign out_ch.valid         = (count_r != '0);
  assign out_ch.code_unit     = q_r[head_r].code_unit;
  assign out_ch.unit_valid    = q_r[head_r].unit_valid;
  assign out_ch.last_of_item  = q_r[head_r].last_of_item;
  assign out_ch.end_of_stream = q_r[head_r].end_of_stream;
  assign out_ch.total_units   = q_r[head_r].total_units;

  // The queue never overfills.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CW'(Q_DEPTH))
    else $error("result queue overfilled");

  // The final byte of a stream leaves a clean decode state.
  a_stream_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.last_byte |=> pend_r == 2'd0 && units_r == '0 && !stopped_r)
    else $error("stream state not cleared after final byte");

  // Once output has stopped, no sequence stays pending.
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> pend_r == 2'd0)
    else $error("sequence pending after output stop");

  // The end of a stream is always the last result of its byte.
  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_stream |-> out_ch.last_of_item)
    else $error("end of stream on a result that is not last of its byte");

endmodule

`default_nettype wire
